// File: hw/rtl/adcdc_pkg.sv
// ----------------------------------------------------------------------------
// adcdc_pkg
// Shared constants and types for the ADC DC-blocking PCM packetizer.
// ----------------------------------------------------------------------------
package adcdc_pkg;

	// Converter code and packet limits
	localparam int CODE_W             = 12;
	localparam int POS_W              = 10;
	localparam int LEN_W              = 11;
	localparam int COEF_W             = 16;
	localparam int X_W                = 16;
	localparam int Y_W                = 24;
	localparam int PCM_W              = 16;

	localparam logic [CODE_W-1:0] MID_CODE = 12'd2048;
	localparam logic [CODE_W-1:0] CODE_MAX = 12'd4095;
	localparam logic [LEN_W-1:0]  MAX_PACKET_SAMPLES = 11'd1024;

	// Configuration register defaults
	localparam logic [COEF_W-1:0] POLE_RESET   = 16'd64853;
	localparam logic [LEN_W-1:0]  PACKET_RESET = 11'd512;

	// Configuration register indexes
	typedef enum logic [0:0] {
		REG_POLE_COEF   = 1'b0,
		REG_PACKET_LEN  = 1'b1
	} cfg_reg_t;

	// Filter saturation bounds (Q3.20)
	localparam logic signed [Y_W-1:0] Y_MAX = 24'sh7FFFFF;
	localparam logic signed [Y_W-1:0] Y_MIN = 24'sh800000;

	// PCM clamp, +-0.999 of full scale
	localparam logic signed [19:0] PCM_LIMIT     = 20'sd32734;
	localparam logic signed [19:0] PCM_LIMIT_NEG = -20'sd32734;

	// Per-sample packet information carried down the pipeline
	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic              last;
		logic [CODE_W-1:0] pmin;
		logic [CODE_W-1:0] pmax;
	} sample_info_t;

	// Filter stage result
	typedef struct packed {
		sample_info_t          info;
		logic signed [Y_W-1:0] y;
	} filt_result_t;

endpackage

// File: hw/rtl/adcdc_front.sv
// ----------------------------------------------------------------------------
// adcdc_front
// Input register: code extraction, packet position and raw min/max tracking.
// ----------------------------------------------------------------------------
module adcdc_front (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [7:0]                            spi_first_byte,
	input  logic [7:0]                            spi_second_byte,
	input  logic                                  transfer_failed,
	input  logic [adcdc_pkg::LEN_W-1:0]           packet_samples,
	output logic                                  s1_valid,
	input  logic                                  s1_ready,
	output adcdc_pkg::sample_info_t               s1_data
);

	logic                               valid_s1;
	adcdc_pkg::sample_info_t            data_s1;
	logic [adcdc_pkg::POS_W-1:0]        pos_q;
	logic [adcdc_pkg::CODE_W-1:0]       min_q;
	logic [adcdc_pkg::CODE_W-1:0]       max_q;

	logic [adcdc_pkg::CODE_W-1:0]       code;
	logic [adcdc_pkg::LEN_W-1:0]        len;
	logic [adcdc_pkg::LEN_W-1:0]        pos_next;
	logic                               last;
	logic [adcdc_pkg::CODE_W-1:0]       new_min;
	logic [adcdc_pkg::CODE_W-1:0]       new_max;
	logic                               accept;

	// Code extraction; failed transfer reads as mid-scale
	assign code = transfer_failed ? adcdc_pkg::MID_CODE
	                              : {spi_first_byte[4:0], spi_second_byte[7:1]};

	// Effective packet length, limited to 1..MAX_PACKET_SAMPLES
	always_comb begin
		if (packet_samples == '0) begin
			len = adcdc_pkg::LEN_W'(1);
		end else if (packet_samples > adcdc_pkg::MAX_PACKET_SAMPLES) begin
			len = adcdc_pkg::MAX_PACKET_SAMPLES;
		end else begin
			len = packet_samples;
		end
	end

	assign pos_next = {1'b0, pos_q} + adcdc_pkg::LEN_W'(1);
	assign last     = (pos_next >= len);
	assign new_min  = (code < min_q) ? code : min_q;
	assign new_max  = (code > max_q) ? code : max_q;

	assign in_ready = !valid_s1 || s1_ready;
	assign accept   = in_valid && in_ready;

	// Packet position and running bounds
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			min_q <= adcdc_pkg::CODE_MAX;
			max_q <= '0;
		end else if (accept) begin
			if (last) begin
				pos_q <= '0;
				min_q <= adcdc_pkg::CODE_MAX;
				max_q <= '0;
			end else begin
				pos_q <= pos_next[adcdc_pkg::POS_W-1:0];
				min_q <= new_min;
				max_q <= new_max;
			end
		end
	end

	// Stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1.code <= code;
			data_s1.last <= last;
			data_s1.pmin <= last ? new_min : '0;
			data_s1.pmax <= last ? new_max : '0;
		end
	end

	assign s1_valid = valid_s1;
	assign s1_data  = data_s1;

endmodule

// File: hw/rtl/adcdc_filter.sv
// ----------------------------------------------------------------------------
// adcdc_filter
// First-order DC blocker y = x - x_prev + R*y_prev in Q3.20 with saturation.
// ----------------------------------------------------------------------------
module adcdc_filter (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s1_valid,
	output logic                                  s1_ready,
	input  adcdc_pkg::sample_info_t               s1_data,
	input  logic [adcdc_pkg::COEF_W-1:0]          pole_coefficient,
	output logic                                  s2_valid,
	input  logic                                  s2_ready,
	output adcdc_pkg::filt_result_t               s2_data
);

	logic                                 valid_s2;
	adcdc_pkg::filt_result_t              data_s2;
	logic signed [adcdc_pkg::X_W-1:0]     prev_in_q;
	logic signed [adcdc_pkg::Y_W-1:0]     prev_out_q;

	logic signed [adcdc_pkg::X_W-1:0]     x;
	logic signed [16:0]                   diff;
	logic signed [21:0]                   diff_sc;
	logic signed [40:0]                   prod;
	logic signed [40:0]                   prod_rnd;
	logic signed [24:0]                   fb;
	logic signed [26:0]                   sum;
	logic signed [adcdc_pkg::Y_W-1:0]     y;
	logic                                 take;

	// Center the code to Q1.15
	assign x = {~s1_data.code[11], s1_data.code[10:0], 4'b0000};

	// Input difference scaled to Q3.20
	assign diff    = {x[15], x} - {prev_in_q[15], prev_in_q};
	assign diff_sc = {diff, 5'b00000};

	// Feedback product, rounded to nearest with ties away from zero
	assign prod     = prev_out_q * $signed({1'b0, pole_coefficient});
	assign prod_rnd = prod + (prod[40] ? 41'sd32767 : 41'sd32768);
	assign fb       = prod_rnd[40:16];

	assign sum = {{5{diff_sc[21]}}, diff_sc} + {{2{fb[24]}}, fb};

	// Saturate to the Q3.20 range
	always_comb begin
		if ((sum[26:23] == 4'b0000) || (sum[26:23] == 4'b1111)) begin
			y = sum[23:0];
		end else if (sum[26]) begin
			y = adcdc_pkg::Y_MIN;
		end else begin
			y = adcdc_pkg::Y_MAX;
		end
	end

	assign s1_ready = !valid_s2 || s2_ready;
	assign take     = s1_valid && s1_ready;

	// Filter history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_in_q  <= '0;
			prev_out_q <= '0;
		end else if (take) begin
			prev_in_q  <= x;
			prev_out_q <= y;
		end
	end

	// Stage 2 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s1_ready) begin
			valid_s2 <= s1_valid;
		end
	end

	// Stage 2 payload
	always_ff @(posedge clk) begin
		if (take) begin
			data_s2.info <= s1_data;
			data_s2.y    <= y;
		end
	end

	assign s2_valid = valid_s2;
	assign s2_data  = data_s2;

endmodule

// File: hw/rtl/adcdc_pcm.sv
// ----------------------------------------------------------------------------
// adcdc_pcm
// Q3.20 to 16-bit PCM: scale by 32767, round half to even, clamp; result reg.
// ----------------------------------------------------------------------------
module adcdc_pcm (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s2_valid,
	output logic                                  s2_ready,
	input  adcdc_pkg::filt_result_t               s2_data,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [adcdc_pkg::PCM_W-1:0]    pcm_sample,
	output logic [adcdc_pkg::CODE_W-1:0]          raw_code,
	output logic                                  packet_end,
	output logic [adcdc_pkg::CODE_W-1:0]          packet_raw_min,
	output logic [adcdc_pkg::CODE_W-1:0]          packet_raw_max
);

	logic                                 valid_q;
	logic signed [adcdc_pkg::PCM_W-1:0]   pcm_q;
	adcdc_pkg::sample_info_t              info_q;

	logic signed [39:0]                   scaled;
	logic signed [19:0]                   quot;
	logic [19:0]                          rem;
	logic                                 round_up;
	logic signed [19:0]                   rounded;
	logic signed [19:0]                   clamped;
	logic                                 take;

	// y * 32767 as (y << 15) - y
	assign scaled = {s2_data.y[23], s2_data.y, 15'b0}
	              - {{16{s2_data.y[23]}}, s2_data.y};

	// Divide by 2^20, round half to even
	assign quot     = scaled[39:20];
	assign rem      = scaled[19:0];
	assign round_up = (rem > 20'h80000) || ((rem == 20'h80000) && quot[0]);
	assign rounded  = quot + $signed({19'b0, round_up});

	// Clamp to +-0.999 of full scale
	always_comb begin
		if (rounded > adcdc_pkg::PCM_LIMIT) begin
			clamped = adcdc_pkg::PCM_LIMIT;
		end else if (rounded < adcdc_pkg::PCM_LIMIT_NEG) begin
			clamped = adcdc_pkg::PCM_LIMIT_NEG;
		end else begin
			clamped = rounded;
		end
	end

	assign s2_ready = !valid_q || out_ready;
	assign take     = s2_valid && s2_ready;

	// Result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (s2_ready) begin
			valid_q <= s2_valid;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (take) begin
			pcm_q  <= clamped[15:0];
			info_q <= s2_data.info;
		end
	end

	assign out_valid      = valid_q;
	assign pcm_sample     = pcm_q;
	assign raw_code       = info_q.code;
	assign packet_end     = info_q.last;
	assign packet_raw_min = info_q.pmin;
	assign packet_raw_max = info_q.pmax;

endmodule

// File: hw/rtl/adc_dc_block_pcm_packetizer.sv
// ----------------------------------------------------------------------------
// adc_dc_block_pcm_packetizer
// Serial ADC frame to DC-blocked 16-bit PCM, grouped into packets with the
// raw min/max reported on the last sample of each packet.
//
//   channel  | handshake            | payload
//   ---------+----------------------+--------------------------------------
//   input    | in_valid / in_ready  | spi_first_byte, spi_second_byte,
//            |                      | transfer_failed
//   output   | out_valid/out_ready  | pcm_sample, raw_code, packet_end,
//            |                      | packet_raw_min, packet_raw_max
//   config   | cfg_we (no wait)     | cfg_index, cfg_data
//
// One transaction per cycle while out_ready holds; out_valid follows input
// acceptance through the input register, filter register, result register.
// The filter feedback (24x16 multiply, round, add, saturate) closes
// combinationally between the filter history registers.
// Reset clears the filter history, packet position and bounds, and loads the
// register defaults. Each stage advances when empty or when the next one
// drains, so a stalled output still lets the earlier stages fill.
// ----------------------------------------------------------------------------
module adc_dc_block_pcm_packetizer (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// Configuration
	input  logic                                  cfg_we,
	input  logic [0:0]                            cfg_index,
	input  logic [adcdc_pkg::COEF_W-1:0]          cfg_data,
	// Input
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [7:0]                            spi_first_byte,
	input  logic [7:0]                            spi_second_byte,
	input  logic                                  transfer_failed,
	// Output
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [adcdc_pkg::PCM_W-1:0]    pcm_sample,
	output logic [adcdc_pkg::CODE_W-1:0]          raw_code,
	output logic                                  packet_end,
	output logic [adcdc_pkg::CODE_W-1:0]          packet_raw_min,
	output logic [adcdc_pkg::CODE_W-1:0]          packet_raw_max
);

	logic [adcdc_pkg::COEF_W-1:0]   pole_q;
	logic [adcdc_pkg::LEN_W-1:0]    packet_len_q;

	logic                           s1_valid;
	logic                           s1_ready;
	adcdc_pkg::sample_info_t        s1_data;
	logic                           s2_valid;
	logic                           s2_ready;
	adcdc_pkg::filt_result_t        s2_data;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pole_q       <= adcdc_pkg::POLE_RESET;
			packet_len_q <= adcdc_pkg::PACKET_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				adcdc_pkg::REG_POLE_COEF:  pole_q       <= cfg_data;
				adcdc_pkg::REG_PACKET_LEN: packet_len_q <= cfg_data[adcdc_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	adcdc_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.spi_first_byte  (spi_first_byte),
		.spi_second_byte (spi_second_byte),
		.transfer_failed (transfer_failed),
		.packet_samples  (packet_len_q),
		.s1_valid        (s1_valid),
		.s1_ready        (s1_ready),
		.s1_data         (s1_data)
	);

	adcdc_filter u_filter (
		.clk              (clk),
		.arst_n           (arst_n),
		.s1_valid         (s1_valid),
		.s1_ready         (s1_ready),
		.s1_data          (s1_data),
		.pole_coefficient (pole_q),
		.s2_valid         (s2_valid),
		.s2_ready         (s2_ready),
		.s2_data          (s2_data)
	);

	adcdc_pcm u_pcm (
		.clk            (clk),
		.arst_n         (arst_n),
		.s2_valid       (s2_valid),
		.s2_ready       (s2_ready),
		.s2_data        (s2_data),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.pcm_sample     (pcm_sample),
		.raw_code       (raw_code),
		.packet_end     (packet_end),
		.packet_raw_min (packet_raw_min),
		.packet_raw_max (packet_raw_max)
	);

	// Bounds are zero on samples that do not close a packet
	a_bounds_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !packet_end) |-> (packet_raw_min == '0 && packet_raw_max == '0))
		else $error("packet bounds nonzero outside packet end");

	// The closing sample's code lies within the packet bounds
	a_bounds_order: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && packet_end) |->
		(packet_raw_min <= raw_code && raw_code <= packet_raw_max))
		else $error("packet bounds do not enclose the closing sample");

	// PCM stays within the clamp limits
	a_pcm_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pcm_sample <= 16'sd32734 && pcm_sample >= -16'sd32734))
		else $error("pcm sample outside clamp range");

	// An empty pipeline always frees the input for a new transaction
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid && !s2_valid && !s1_valid) |-> in_ready)
		else $error("input stalled with an empty pipeline");

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the ADC DC-blocking PCM packetizer. A predictor
// computes the expected PCM sample and packet marking for every accepted
// frame. Results are compared field by field in order while both handshakes
// idle and stall at random. Directed frames come first, then random
// waveforms under changing pole and packet-length settings.
// ----------------------------------------------------------------------------
module testbench;
	import adcdc_pkg::*;

	// Expected content of one output transaction
	typedef struct {
		logic signed [PCM_W-1:0] pcm;
		logic [CODE_W-1:0]       code;
		logic                    last;
		logic [CODE_W-1:0]       pmin;
		logic [CODE_W-1:0]       pmax;
	} pcm_result_t;

	// Predictor and in-order checker of the filtered samples
	class pcm_checker;
		logic [COEF_W-1:0] pole;
		logic [LEN_W-1:0]  pkt_len;
		int                prev_x;
		int                prev_y;
		int unsigned       position;
		logic [CODE_W-1:0] lo_code;
		logic [CODE_W-1:0] hi_code;
		pcm_result_t       pending_samples[$];
		int                errors;
		int                checked;

		function new();
			pole     = POLE_RESET;
			pkt_len  = PACKET_RESET;
			prev_x   = 0;
			prev_y   = 0;
			position = 0;
			lo_code  = CODE_MAX;
			hi_code  = '0;
			errors   = 0;
			checked  = 0;
		endfunction

		// Divide by 2^sh, rounding to nearest; ties away from zero or to even
		static function longint div_round(longint v, int sh, bit ties_even);
			longint mag;
			longint q;
			longint rem;
			longint half;
			bit     neg;
			neg  = v < 0;
			mag  = neg ? -v : v;
			q    = mag >>> sh;
			rem  = mag & ((64'sd1 << sh) - 1);
			half = 64'sd1 << (sh - 1);
			if (rem > half || (rem == half && (!ties_even || q[0])))
				q++;
			return neg ? -q : q;
		endfunction

		function void set_reg(cfg_reg_t idx, logic [COEF_W-1:0] value);
			if (idx == REG_POLE_COEF)
				pole = value;
			else
				pkt_len = value[LEN_W-1:0];
		endfunction

		// Accepted input frame: filter it and queue the expected sample
		function void note_input(logic [7:0] b0, logic [7:0] b1, logic failed);
			logic [CODE_W-1:0] code;
			int                x;
			int unsigned       eff_len;
			longint            y;
			longint            pcm;
			pcm_result_t       r;
			code = failed ? MID_CODE : {b0[4:0], b1[7:1]};
			x    = (int'(code) - 2048) * 16;

			// DC blocker, Q3.20 state, rounded feedback product
			y = longint'(x - prev_x) * 32
				+ div_round(longint'(prev_y) * longint'(pole), 16, 1'b0);
			if (y > longint'(Y_MAX)) y = longint'(Y_MAX);
			if (y < longint'(Y_MIN)) y = longint'(Y_MIN);
			prev_x = x;
			prev_y = int'(y);

			// Scale to PCM, round half to even, clamp to +-0.999
			pcm = div_round(y * 32767, 20, 1'b1);
			if (pcm > longint'(PCM_LIMIT)) pcm = longint'(PCM_LIMIT);
			if (pcm < longint'(PCM_LIMIT_NEG)) pcm = longint'(PCM_LIMIT_NEG);

			// Packet bounds and position
			if (code < lo_code) lo_code = code;
			if (code > hi_code) hi_code = code;
			eff_len = 32'(pkt_len);
			if (eff_len == 0) eff_len = 1;
			if (eff_len > 32'(MAX_PACKET_SAMPLES)) eff_len = 32'(MAX_PACKET_SAMPLES);

			r.pcm  = pcm[PCM_W-1:0];
			r.code = code;
			r.last = (position + 1 >= eff_len);
			r.pmin = r.last ? lo_code : '0;
			r.pmax = r.last ? hi_code : '0;
			if (r.last) begin
				position = 0;
				lo_code  = CODE_MAX;
				hi_code  = '0;
			end else begin
				position++;
			end
			pending_samples.push_back(r);
		endfunction

		task report(string msg);
			if (errors < 50)
				$display("ERROR @%0t: %s", $realtime, msg);
			errors++;
		endtask

		// Accepted output transaction: compare with the oldest expectation
		task check_result(logic signed [PCM_W-1:0] pcm, logic [CODE_W-1:0] code,
				logic last, logic [CODE_W-1:0] pmin, logic [CODE_W-1:0] pmax);
			pcm_result_t e;
			if (pending_samples.size() == 0) begin
				report("output transaction with no sample expected");
				return;
			end
			e = pending_samples.pop_front();
			if (pcm !== e.pcm)
				report($sformatf("sample %0d: pcm_sample %0d, expected %0d",
					checked, pcm, e.pcm));
			if (code !== e.code)
				report($sformatf("sample %0d: raw_code %0d, expected %0d",
					checked, code, e.code));
			if (last !== e.last)
				report($sformatf("sample %0d: packet_end %0b, expected %0b",
					checked, last, e.last));
			if (pmin !== e.pmin)
				report($sformatf("sample %0d: packet_raw_min %0d, expected %0d",
					checked, pmin, e.pmin));
			if (pmax !== e.pmax)
				report($sformatf("sample %0d: packet_raw_max %0d, expected %0d",
					checked, pmax, e.pmax));
			checked++;
		endtask
	endclass

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_we;
	logic [0:0]              cfg_index;
	logic [COEF_W-1:0]       cfg_data;
	logic                    in_valid;
	logic                    in_ready;
	logic [7:0]              spi_first_byte;
	logic [7:0]              spi_second_byte;
	logic                    transfer_failed;
	logic                    out_valid;
	logic                    out_ready;
	logic signed [PCM_W-1:0] pcm_sample;
	logic [CODE_W-1:0]       raw_code;
	logic                    packet_end;
	logic [CODE_W-1:0]       packet_raw_min;
	logic [CODE_W-1:0]       packet_raw_max;

	pcm_checker pcm_model = new();
	bit         tx_burst  = 1'b0;
	bit         rx_burst  = 1'b0;

	adc_dc_block_pcm_packetizer DUT (.*);

	// Clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Send one frame; random gap before it, hold until accepted
	task automatic send_frame(input logic [7:0] b0, input logic [7:0] b1,
			input logic failed);
		int gap;
		if ($urandom_range(0, 15) == 0) tx_burst = !tx_burst;
		gap = tx_burst ? 0 : $urandom_range(0, 8);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid        <= 1'b1;
		spi_first_byte  <= b0;
		spi_second_byte <= b1;
		transfer_failed <= failed;
		do @(posedge clk); while (!in_ready);
		pcm_model.note_input(b0, b1, failed);
	endtask

	// Frame carrying a given code; unused bits random
	task automatic send_code(input int code, input logic failed);
		logic [CODE_W-1:0] c;
		c = code[CODE_W-1:0];
		send_frame({3'($urandom_range(0, 7)), c[11:7]},
			{c[6:0], 1'($urandom_range(0, 1))}, failed);
	endtask

	// Stop sending until every expected sample has come back
	task automatic drain_samples();
		in_valid <= 1'b0;
		do @(posedge clk); while (pcm_model.pending_samples.size() != 0);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [COEF_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		pcm_model.set_reg(idx, value);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Random pole and packet length, extremes favored
	task automatic pick_settings();
		logic [COEF_W-1:0] pole;
		logic [LEN_W-1:0]  len;
		case ($urandom_range(0, 4))
			0: pole = '0;
			1: pole = 16'd65529;
			2: pole = 16'hFFFF;
			3: pole = POLE_RESET;
			default: pole = 16'($urandom_range(0, 65535));
		endcase
		case ($urandom_range(0, 7))
			0: len = 11'd1;
			1: len = 11'd2;
			2: len = 11'd0;
			3: len = MAX_PACKET_SAMPLES;
			4: len = 11'h7FF;
			default: len = 11'($urandom_range(3, 24));
		endcase
		if ($urandom_range(0, 3) != 0) write_reg(REG_POLE_COEF, pole);
		write_reg(REG_PACKET_LEN, {5'($urandom_range(0, 31)), len});
	endtask

	// Output side: random stalls, check each transaction
	initial begin
		int stall;
		out_ready <= 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			if ($urandom_range(0, 15) == 0) rx_burst = !rx_burst;
			stall = rx_burst ? 0 : $urandom_range(0, 8);
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			pcm_model.check_result(pcm_sample, raw_code, packet_end,
				packet_raw_min, packet_raw_max);
		end
	end

	// Stimulus
	initial begin
		int total;
		int seg;
		int n;
		int kind;
		int lvl;
		int dir;
		int step;
		int lo_c;
		int hi_c;
		int run;
		int wait_cycles;
		bit long_done;
		arst_n          = 1'b0;
		cfg_we          <= 1'b0;
		cfg_index       <= REG_POLE_COEF;
		cfg_data        <= '0;
		in_valid        <= 1'b0;
		spi_first_byte  <= '0;
		spi_second_byte <= '0;
		transfer_failed <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Field extremes, failed transfer, junk bits, PCM clamp both ways
		write_reg(REG_PACKET_LEN, 16'd4);
		send_frame(8'h00, 8'h00, 1'b0);
		send_frame(8'hFF, 8'hFF, 1'b0);
		send_frame(8'h00, 8'h00, 1'b0);
		send_frame(8'hFF, 8'hFF, 1'b1);
		send_frame(8'hE0, 8'h01, 1'b0);
		send_frame(8'h1F, 8'hFE, 1'b0);

		// Pole zero, packet length zero; half-scale steps hit the PCM tie
		drain_samples();
		write_reg(REG_POLE_COEF, 16'd0);
		write_reg(REG_PACKET_LEN, 16'd0);
		send_code(2048, 1'b0);
		send_code(3072, 1'b0);
		send_code(2048, 1'b0);

		// Pole of one half: every odd feedback state gives a rounding tie
		drain_samples();
		write_reg(REG_POLE_COEF, 16'd32768);
		send_code(4095, 1'b0);
		send_code(4095, 1'b0);
		send_code(0, 1'b0);

		// Pole above range, packet length above the maximum
		drain_samples();
		write_reg(REG_POLE_COEF, 16'hFFFF);
		write_reg(REG_PACKET_LEN, 16'hFFFF);
		send_code(0, 1'b0);
		repeat (4) send_code(4095, 1'b0);

		// Length lowered below the current position ends the packet
		drain_samples();
		write_reg(REG_PACKET_LEN, 16'd3);
		send_code(2048, 1'b0);

		drain_samples();
		write_reg(REG_POLE_COEF, 16'd65529);
		send_code(0, 1'b0);
		send_code(4095, 1'b0);

		// Random waveforms in segments
		total     = 0;
		seg       = 0;
		long_done = 1'b0;
		while (total < 750 || !long_done) begin
			if (seg == 2) begin
				// One full packet of the largest length, from position zero
				drain_samples();
				write_reg(REG_PACKET_LEN, 16'd1);
				send_code($urandom_range(0, 4095), 1'b0);
				drain_samples();
				write_reg(REG_PACKET_LEN, $urandom_range(0, 1) ? 16'd1024 : 16'h07FF);
				n         = MAX_PACKET_SAMPLES + 8;
				long_done = 1'b1;
			end else begin
				if ($urandom_range(0, 1) != 0) begin
					drain_samples();
					pick_settings();
				end
				n = $urandom_range(10, 80);
			end
			kind = $urandom_range(0, 3);
			lvl  = $urandom_range(0, 4095);
			dir  = 1;
			step = $urandom_range(16, 400);
			lo_c = $urandom_range(0, 1) ? 0 : $urandom_range(0, 2047);
			hi_c = $urandom_range(0, 1) ? 4095 : $urandom_range(2048, 4095);
			run  = $urandom_range(1, 6);
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(0, 63) == 0) drain_samples();
				case (kind)
					0: send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
						$urandom_range(0, 7) == 0);
					1: send_code(((i / run) % 2) ? hi_c : lo_c, $urandom_range(0, 31) == 0);
					2: begin
						lvl += dir * step;
						if (lvl > 4095) begin
							lvl = 4095;
							dir = -1;
						end
						if (lvl < 0) begin
							lvl = 0;
							dir = 1;
						end
						send_code(lvl, $urandom_range(0, 31) == 0);
					end
					default: begin
						step = lvl + $urandom_range(0, 32) - 16;
						if (step > 4095) step = 4095;
						if (step < 0) step = 0;
						send_code(step, $urandom_range(0, 31) == 0);
					end
				endcase
			end
			total += n;
			seg++;
		end

		// Wait for the last samples, then a few quiet cycles
		in_valid <= 1'b0;
		wait_cycles = 0;
		while (pcm_model.pending_samples.size() != 0 && wait_cycles < 10000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (10) @(posedge clk);
		if (pcm_model.pending_samples.size() != 0)
			pcm_model.report($sformatf("%0d samples never arrived",
				pcm_model.pending_samples.size()));
		if (pcm_model.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Run limit
	initial begin
		#2_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule

// File: adc_dc_block_pcm_packetizer.f
hw/rtl/adcdc_pkg.sv
hw/rtl/adcdc_front.sv
hw/rtl/adcdc_filter.sv
hw/rtl/adcdc_pcm.sv
hw/rtl/adc_dc_block_pcm_packetizer.sv
tb/testbench.sv
